@@ design/psfp_pkg.sv @@
// ============================================================================
// Particle sensor frame parser package
// Shared types and constants for the frame parser front end, queue and back end.
// ============================================================================
package psfp_pkg;

    localparam logic [7:0] START_BYTE_RESET = 8'h42;
    localparam int         QUEUE_DEPTH      = 4;

    typedef struct packed {
        logic wr;
        logic emit;
        logic err;
    } t_cmd_op;

    localparam int OP_W = $bits(t_cmd_op);

endpackage

@@ design/psfp_byte_if.sv @@
// ============================================================================
// Byte channel
// Valid/ready channel carrying one received serial byte per word.
// ============================================================================
interface psfp_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);

endinterface

@@ design/psfp_res_if.sv @@
// ============================================================================
// Result channel
// Valid/ready channel carrying one decoded frame word or an error result.
// ============================================================================
interface psfp_res_if;

    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        status;
    logic        last;

    modport source (output valid, output word_index, output word_value,
                    output status, output last, input ready);
    modport sink   (input valid, input word_index, input word_value,
                    input status, input last, output ready);

endinterface

@@ design/psfp_front.sv @@
// ============================================================================
// Frame parser front end
// Tracks framing, sums the header and payload, pairs bytes into words and
// issues store, emit and error commands to the queue.
// ============================================================================
module psfp_front #(
    parameter  int FRAME_BYTES = 32,
    localparam int WORD_COUNT  = (FRAME_BYTES - 2) / 2,
    localparam int ADDR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
    localparam int CMD_W       = psfp_pkg::OP_W + ADDR_W + 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    psfp_byte_if.sink             i_byte,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    output logic                  o_push,
    output logic [CMD_W-1:0]      o_cmd,
    input  logic                  i_full
);

    localparam int CNT_W      = $clog2(FRAME_BYTES);

    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [15:0]      r_sum,      n_sum;
    logic [7:0]       r_hold,     n_hold;
    logic [15:0]      r_last_word, n_last_word;
    logic [7:0]       r_start;

    logic             accept;
    logic [7:0]       b;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] widx;
    logic [15:0]      new_word;
    logic [15:0]      check_word;
    logic             wr;
    logic             fin;
    logic             last_slot;
    psfp_pkg::t_cmd_op op;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;
    assign b            = i_byte.byte_value;
    assign pos          = r_count - CNT_W'(2);
    assign widx         = pos >> 1;
    assign new_word     = {r_hold, b};
    assign last_slot    = (widx == CNT_W'(WORD_COUNT - 1));

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_sum       = r_sum;
        n_hold      = r_hold;
        n_last_word = r_last_word;
        wr          = 1'b0;
        fin         = 1'b0;
        if (accept) begin
            if (!r_in_frame) begin
                if (b == r_start) begin
                    n_in_frame = 1'b1;
                    n_count    = CNT_W'(1);
                    n_sum      = {8'h00, b};
                end
            end else begin
                if (r_count < CNT_W'(FRAME_BYTES - 2)) begin
                    n_sum = r_sum + {8'h00, b};
                end
                if (r_count >= CNT_W'(2)) begin
                    if (!pos[0]) begin
                        n_hold = b;
                    end else if (widx < CNT_W'(WORD_COUNT)) begin
                        wr = 1'b1;
                        if (last_slot) begin
                            n_last_word = new_word;
                        end
                    end
                end
                n_count = r_count + CNT_W'(1);
                if (r_count == CNT_W'(FRAME_BYTES - 1)) begin
                    fin        = 1'b1;
                    n_in_frame = 1'b0;
                    n_count    = '0;
                end
            end
        end
    end

    assign check_word = (wr && last_slot) ? new_word : r_last_word;

    always_comb begin
        op.wr   = wr;
        op.emit = fin && (r_sum == check_word);
        op.err  = fin && (r_sum != check_word);
    end

    assign o_push = accept && (wr || fin);
    assign o_cmd  = {op, ADDR_W'(widx), new_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_hold     <= '0;
            r_start    <= psfp_pkg::START_BYTE_RESET;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_hold     <= n_hold;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_word <= n_last_word;
    end

endmodule

@@ design/psfp_queue.sv @@
// ============================================================================
// Command queue
// Short first-in first-out buffer between the front and back ends.
// ============================================================================
module psfp_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
            end
            if (do_pop) begin
                r_head <= (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ design/psfp_back.sv @@
// ============================================================================
// Frame parser back end
// Stores decoded words, and on a frame end emits either the word list or a
// single error result through a registered output.
// ============================================================================
module psfp_back #(
    parameter  int FRAME_BYTES = 32,
    localparam int WORD_COUNT  = (FRAME_BYTES - 2) / 2,
    localparam int ADDR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
    localparam int CMD_W       = psfp_pkg::OP_W + ADDR_W + 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  logic [CMD_W-1:0]      i_cmd,
    output logic                  o_pop,
    psfp_res_if.source            o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

    t_state            r_state;
    logic [15:0]       r_mem [WORD_COUNT];
    logic [15:0]       r_rd_data;
    logic [ADDR_W-1:0] r_idx;
    logic              r_out_valid;
    logic [3:0]        r_out_index;
    logic [15:0]       r_out_value;
    logic              r_out_status;
    logic              r_out_last;

    psfp_pkg::t_cmd_op cmd_op;
    logic [ADDR_W-1:0] cmd_addr;
    logic [15:0]       cmd_data;
    logic              out_free;
    logic              pop;
    logic              idx_last;
    logic              load;

    assign cmd_op   = i_cmd[CMD_W-1 -: psfp_pkg::OP_W];
    assign cmd_addr = i_cmd[16 +: ADDR_W];
    assign cmd_data = i_cmd[15:0];
    assign out_free = !r_out_valid || o_res.ready;
    assign pop      = (r_state == ST_IDLE) && i_cmd_valid && out_free;
    assign idx_last = (r_idx == ADDR_W'(WORD_COUNT - 1));
    assign o_pop    = pop;
    assign load     = (pop && cmd_op.err) || ((r_state == ST_SHOW) && out_free);

    always_ff @(posedge i_clk) begin
        if (pop && cmd_op.wr) begin
            r_mem[cmd_addr] <= cmd_data;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        if (cmd_op.err) begin
                            r_out_index  <= '0;
                            r_out_value  <= '0;
                            r_out_status <= 1'b1;
                            r_out_last   <= 1'b1;
                        end else if (cmd_op.emit) begin
                            r_idx   <= '0;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (out_free) begin
                        r_out_index  <= 4'(r_idx);
                        r_out_value  <= r_rd_data;
                        r_out_status <= 1'b0;
                        r_out_last   <= idx_last;
                        if (idx_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + ADDR_W'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.word_index = r_out_index;
    assign o_res.word_value = r_out_value;
    assign o_res.status     = r_out_status;
    assign o_res.last       = r_out_last;

endmodule

@@ design/particle_sensor_frame_parser.sv @@
// ============================================================================
// Particle sensor frame parser
// Bytes enter on i_byte (valid/ready, one byte per word). Outside a frame any
// byte other than the configured start byte is dropped; the start byte opens
// a frame of FRAME_BYTES bytes. Words go out on o_res (valid/ready): on a good
// checksum all (FRAME_BYTES-2)/2 words in order with last set on the final
// one, otherwise one result with status 1, index 0, value 0 and last set.
// i_cfg_we/i_cfg_wdata write the start byte (reset 0x42); write when idle.
// The front end posts word stores and the frame-end command into a four-entry
// queue; on a frame-end command the back end reads each word from its word
// memory through a registered read and then loads it into its output register,
// and it pops no further command until the last word is loaded. When o_res
// stalls the back end holds its output and stops draining; once the queue
// fills, i_byte.ready drops until it drains.
// Synchronous active-low reset empties the queue, closes any open frame and
// drops any result in flight.
// ============================================================================
module particle_sensor_frame_parser #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psfp_byte_if.sink   i_byte,
    psfp_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int WORD_COUNT = (FRAME_BYTES - 2) / 2;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CMD_W      = psfp_pkg::OP_W + ADDR_W + 16;

    logic             push;
    logic [CMD_W-1:0] push_cmd;
    logic             full;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd;
    logic             pop;

    psfp_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    psfp_queue #(
        .WIDTH (CMD_W),
        .DEPTH (psfp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_data  (cmd),
        .i_pop   (pop)
    );

    psfp_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule
